// File: sv/rbfk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbfk_pkg: shared types and constants of the RBF kernel element core
// Fixed-point formats, register indexes, operation codes and the item types
// that travel between the front end, the request queue and the back end.
// ----------------------------------------------------------------------------
package rbfk_pkg;

    // Fraction bits of the squared distance, scale and kernel value
    localparam int FRAC_BITS  = 16;

    localparam int DIST_W     = 32;
    localparam int COEFF_W    = 32;
    localparam int KVAL_W     = 34;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Square root: radicand is d2 scaled up by FRAC_BITS, two bits per digit
    localparam int RAD_W      = DIST_W + FRAC_BITS;
    localparam int ROOT_W     = (RAD_W + 1) / 2;
    localparam int RADP_W     = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 3;

    // Exponent product and its split into integer and fraction parts
    localparam int PROD_W     = COEFF_W + DIST_W;
    localparam int UNDER_W    = 5;

    // Q1.31 series arithmetic
    localparam int QW         = 32;
    localparam int Q_FRAC     = 31;
    localparam int SUM_W      = QW + 2;
    localparam int SERIES_N   = 15;
    localparam int POW_STAGES = (1 << UNDER_W) - 1;
    localparam int RND_SHIFT  = Q_FRAC - FRAC_BITS;
    localparam int RVAL_W     = QW + 1 - RND_SHIFT;

    localparam logic [QW-1:0] Q_ONE  = QW'(64'd1 << Q_FRAC);
    // exp(-1) in Q1.31 as the truncated series gives it
    localparam logic [QW-1:0] E1_Q31 = QW'(64'd790015085);
    localparam logic [QW:0]   RND_HALF = (QW+1)'(64'd1 << (RND_SHIFT - 1));

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_COEFF = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SIGMA_INF   = CFG_IDX_W'(2);

    // Kernel mode codes
    localparam logic [MODE_W-1:0] MODE_GAUSS   = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_LAPLACE = MODE_W'(1);

    localparam logic [COEFF_W-1:0] SCALE_RESET = COEFF_W'(64'd65536);

    typedef enum logic [1:0] {
        OP_GAUSS,
        OP_LAPLACE,
        OP_NEG,
        OP_ERR
    } op_t;

    typedef struct packed {
        logic [DIST_W-1:0] d2;
        logic              eom;
        op_t               op;
    } item_t;

    typedef struct packed {
        item_t              item;
        logic               under;
        logic [UNDER_W-1:0] n;
    } ctl_t;

endpackage
`default_nettype wire

// File: sv/rbfk_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbfk_front: configuration registers and request classification
// Holds the kernel mode, scale and infinite-sigma flag, and tags each incoming
// request with the operation the back end must carry out.
// ----------------------------------------------------------------------------
module rbfk_front (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [rbfk_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rbfk_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [rbfk_pkg::DIST_W-1:0]        distance_sq,
    input  wire logic                               end_of_matrix,
    output rbfk_pkg::item_t                         item,
    output logic [rbfk_pkg::COEFF_W-1:0]            scale_coeff
);
    import rbfk_pkg::*;

    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [COEFF_W-1:0] scale_reg, scale_next;
    logic               sinf_reg, sinf_next;

    assign cfg_ready = 1'b1;

    // Decode register writes
    always_comb
    begin
        mode_next  = mode_reg;
        scale_next = scale_reg;
        sinf_next  = sinf_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_KERNEL_MODE: mode_next  = cfg_data[MODE_W-1:0];
                REG_SCALE_COEFF: scale_next = cfg_data[COEFF_W-1:0];
                REG_SIGMA_INF:   sinf_next  = cfg_data[0];
                default:         mode_next  = mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_GAUSS;
            scale_reg <= SCALE_RESET;
            sinf_reg  <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            scale_reg <= scale_next;
            sinf_reg  <= sinf_next;
        end
    end

    assign scale_coeff = scale_reg;

    // Tag the request with its operation
    always_comb
    begin
        item.d2  = distance_sq;
        item.eom = end_of_matrix;
        unique case (mode_reg)
            MODE_GAUSS:   item.op = sinf_reg ? OP_NEG : OP_GAUSS;
            MODE_LAPLACE: item.op = OP_LAPLACE;
            default:      item.op = OP_ERR;
        endcase
    end

endmodule
`default_nettype wire

// File: sv/rbfk_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbfk_queue: two-entry request queue between front and back end
// Registered full flag, so the input side never waits on the result side
// combinationally.
// ----------------------------------------------------------------------------
module rbfk_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr,
    input  wire rbfk_pkg::item_t wr_item,
    output logic                 full,
    input  wire logic            rd,
    output logic                 empty,
    output rbfk_pkg::item_t      rd_item
);
    import rbfk_pkg::*;

    item_t       slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_wr, do_rd;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_item = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 2'd1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the request
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_item;
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("request queue count out of range");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("request queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

// File: sv/rbfk_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbfk_sqrt: pipelined integer square root
// One root digit per stage over the scaled squared distance; the request
// rides along so both kernel modes keep the same latency.
// ----------------------------------------------------------------------------
module rbfk_sqrt (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         adv,
    input  wire logic                         in_valid,
    input  wire rbfk_pkg::item_t              in_item,
    output logic                              out_valid,
    output rbfk_pkg::item_t                   out_item,
    output logic [rbfk_pkg::ROOT_W-1:0]       out_root
);
    import rbfk_pkg::*;

    logic              vld_reg  [ROOT_W];
    logic [RADP_W-1:0] rad_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    item_t             item_reg [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_digit
        logic              vld_in;
        logic [RADP_W-1:0] rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        item_t             item_in;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;
        logic              take;

        if (j == 0)
        begin : g_head
            assign vld_in  = in_valid;
            assign rad_in  = RADP_W'({in_item.d2, {FRAC_BITS{1'b0}}});
            assign rem_in  = '0;
            assign root_in = '0;
            assign item_in = in_item;
        end
        else
        begin : g_tail
            assign vld_in  = vld_reg[j-1];
            assign rad_in  = rad_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign item_in = item_reg[j-1];
        end

        // Bring down two radicand bits and try the next digit
        assign rem_sh    = {rem_in[REM_W-3:0], rad_in[RADP_W-1 -: 2]};
        assign trial     = REM_W'({root_in, 2'b01});
        assign take      = (rem_sh >= trial);
        assign rem_next  = take ? (rem_sh - trial) : rem_sh;
        assign root_next = {root_in[ROOT_W-2:0], take};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else if (adv)
                vld_reg[j] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rad_reg[j]  <= rad_in << 2;
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
                item_reg[j] <= item_in;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_item  = item_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];

`ifndef ASSERT_OFF
    logic [63:0] chk_rad;
    logic [63:0] chk_root;
    assign chk_rad  = 64'({out_item.d2, {FRAC_BITS{1'b0}}});
    assign chk_root = 64'(out_root);

    a_root_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (chk_root * chk_root <= chk_rad))
        else $error("square root too large");

    a_root_high: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((chk_root + 64'd1) * (chk_root + 64'd1) > chk_rad))
        else $error("square root too small");
`endif

endmodule
`default_nettype wire

// File: sv/rbfk_exp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbfk_exp: pipelined negative exponential and result register
// Scales the operand, evaluates exp(-f) by a staged Taylor series, applies
// exp(-1) once per integer unit of the exponent, rounds and selects the result.
// ----------------------------------------------------------------------------
module rbfk_exp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          adv,
    input  wire logic                          in_valid,
    input  wire rbfk_pkg::item_t               in_item,
    input  wire logic [rbfk_pkg::ROOT_W-1:0]   in_root,
    input  wire logic [rbfk_pkg::COEFF_W-1:0]  scale_coeff,
    output logic                               out_valid,
    output logic signed [rbfk_pkg::KVAL_W-1:0] kernel_value,
    output logic                               mode_error,
    output logic                               eom_out
);
    import rbfk_pkg::*;

    // ---------------- exponent product ----------------
    logic [DIST_W-1:0]    operand;
    logic [PROD_W-1:0]    x_prod;
    ctl_t                 m_ctl_next;
    logic                 m_vld_reg;
    ctl_t                 m_ctl_reg;
    logic [FRAC_BITS-1:0] m_f_reg;

    assign operand = (in_item.op == OP_LAPLACE) ? DIST_W'(in_root) : in_item.d2;
    assign x_prod  = {{(PROD_W-COEFF_W){1'b0}}, scale_coeff}
                   * {{(PROD_W-DIST_W){1'b0}}, operand};

    // Split into integer part and truncated fraction
    always_comb
    begin
        m_ctl_next.item  = in_item;
        m_ctl_next.under = |x_prod[PROD_W-1:2*FRAC_BITS+UNDER_W];
        m_ctl_next.n     = x_prod[2*FRAC_BITS+UNDER_W-1:2*FRAC_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_vld_reg <= 1'b0;
        else if (adv)
            m_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_ctl_reg <= m_ctl_next;
            m_f_reg   <= x_prod[2*FRAC_BITS-1:FRAC_BITS];
        end
    end

    // ---------------- series exp(-f), three stages per term ----------------
    logic                    t_vld_reg  [1:SERIES_N];
    ctl_t                    t_ctl_reg  [1:SERIES_N];
    logic [FRAC_BITS-1:0]    t_f_reg    [1:SERIES_N];
    logic [QW-1:0]           t_term_reg [1:SERIES_N];
    logic signed [SUM_W-1:0] t_sum_reg  [1:SERIES_N];

    for (genvar k = 1; k <= SERIES_N; k++)
    begin : g_term
        localparam int K = k;
        localparam logic [QW-1:0] KQ = QW'(K);
        localparam bit ODD = ((K % 2) == 1);

        logic                    v_in;
        ctl_t                    c_in;
        logic [FRAC_BITS-1:0]    f_in;
        logic [QW-1:0]           t_in;
        logic signed [SUM_W-1:0] s_in;

        logic [QW+FRAC_BITS-1:0] mul_a;
        logic                    a_vld_reg;
        ctl_t                    a_ctl_reg;
        logic [FRAC_BITS-1:0]    a_f_reg;
        logic signed [SUM_W-1:0] a_sum_reg;
        logic [QW-1:0]           a_p_reg;

        logic [QW-1:0]           q_est_next;
        logic                    b_vld_reg;
        ctl_t                    b_ctl_reg;
        logic [FRAC_BITS-1:0]    b_f_reg;
        logic signed [SUM_W-1:0] b_sum_reg;
        logic [QW-1:0]           b_p_reg;
        logic [QW-1:0]           b_q_reg;

        logic [QW-1:0]           back_prod;
        logic [QW-1:0]           rem;
        logic [QW-1:0]           term_next;
        logic signed [SUM_W-1:0] term_ext;
        logic signed [SUM_W-1:0] sum_next;

        if (k == 1)
        begin : g_first
            assign v_in = m_vld_reg;
            assign c_in = m_ctl_reg;
            assign f_in = m_f_reg;
            assign t_in = Q_ONE;
            assign s_in = $signed({{(SUM_W-QW){1'b0}}, Q_ONE});
        end
        else
        begin : g_chain
            assign v_in = t_vld_reg[k-1];
            assign c_in = t_ctl_reg[k-1];
            assign f_in = t_f_reg[k-1];
            assign t_in = t_term_reg[k-1];
            assign s_in = t_sum_reg[k-1];
        end

        // Multiply previous term by the argument
        assign mul_a = (QW+FRAC_BITS)'(t_in) * (QW+FRAC_BITS)'(f_in);

        // Estimate quotient by k through its reciprocal
        if (k == 1)
        begin : g_unit
            assign q_est_next = a_p_reg;
        end
        else
        begin : g_recip
            localparam logic [QW-1:0] RECIP = QW'((64'd1 << QW) / K);
            logic [2*QW-1:0] mul_b;
            assign mul_b      = (2*QW)'(a_p_reg) * (2*QW)'(RECIP);
            assign q_est_next = mul_b[2*QW-1:QW];
        end

        // Correct the estimate and fold the term into the sum
        assign back_prod = b_q_reg * KQ;
        assign rem       = b_p_reg - back_prod;
        assign term_next = (rem >= KQ) ? (b_q_reg + QW'(1)) : b_q_reg;
        assign term_ext  = $signed({{(SUM_W-QW){1'b0}}, term_next});
        assign sum_next  = ODD ? (b_sum_reg - term_ext) : (b_sum_reg + term_ext);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_vld_reg    <= 1'b0;
                b_vld_reg    <= 1'b0;
                t_vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                a_vld_reg    <= v_in;
                b_vld_reg    <= a_vld_reg;
                t_vld_reg[k] <= b_vld_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                a_ctl_reg     <= c_in;
                a_f_reg       <= f_in;
                a_sum_reg     <= s_in;
                a_p_reg       <= mul_a[QW+FRAC_BITS-1:FRAC_BITS];
                b_ctl_reg     <= a_ctl_reg;
                b_f_reg       <= a_f_reg;
                b_sum_reg     <= a_sum_reg;
                b_p_reg       <= a_p_reg;
                b_q_reg       <= q_est_next;
                t_ctl_reg[k]  <= b_ctl_reg;
                t_f_reg[k]    <= b_f_reg;
                t_term_reg[k] <= term_next;
                t_sum_reg[k]  <= sum_next;
            end
        end
    end

    // ---------------- integer part: one exp(-1) factor per stage ----------------
    logic          pw_vld_reg [POW_STAGES];
    ctl_t          pw_ctl_reg [POW_STAGES];
    logic [QW-1:0] pw_r_reg   [POW_STAGES];
    logic [QW-1:0] series_val;

    // Clamp a negative series sum to zero
    assign series_val = t_sum_reg[SERIES_N][SUM_W-1] ? '0 : t_sum_reg[SERIES_N][QW-1:0];

    for (genvar i = 0; i < POW_STAGES; i++)
    begin : g_pow
        logic          v_in;
        ctl_t          c_in;
        logic [QW-1:0] r_in;
        logic [2*QW-1:0] mul_e;
        logic [QW-1:0] r_next;

        if (i == 0)
        begin : g_first
            assign v_in = t_vld_reg[SERIES_N];
            assign c_in = t_ctl_reg[SERIES_N];
            assign r_in = series_val;
        end
        else
        begin : g_chain
            assign v_in = pw_vld_reg[i-1];
            assign c_in = pw_ctl_reg[i-1];
            assign r_in = pw_r_reg[i-1];
        end

        assign mul_e  = (2*QW)'(r_in) * (2*QW)'(E1_Q31);
        assign r_next = (c_in.n > UNDER_W'(i)) ? mul_e[QW+Q_FRAC-1:Q_FRAC] : r_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                pw_vld_reg[i] <= 1'b0;
            else if (adv)
                pw_vld_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pw_ctl_reg[i] <= c_in;
                pw_r_reg[i]   <= r_next;
            end
        end
    end

    // ---------------- round and select result ----------------
    logic [QW:0]                rnd_sum;
    logic [RVAL_W-1:0]          rnd_val;
    ctl_t                       f_ctl;
    logic signed [KVAL_W-1:0]   kval_next;
    logic                       out_vld_reg;
    logic signed [KVAL_W-1:0]   kval_reg;
    logic                       merr_reg;
    logic                       eom_reg;

    assign f_ctl   = pw_ctl_reg[POW_STAGES-1];
    assign rnd_sum = {1'b0, pw_r_reg[POW_STAGES-1]} + RND_HALF;
    assign rnd_val = rnd_sum[QW:RND_SHIFT];

    always_comb
    begin
        unique case (f_ctl.item.op)
            OP_GAUSS, OP_LAPLACE:
                kval_next = f_ctl.under ? '0 : $signed(KVAL_W'(rnd_val));
            OP_NEG:
                kval_next = $signed(KVAL_W'(0) - KVAL_W'(f_ctl.item.d2));
            OP_ERR:
                kval_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= pw_vld_reg[POW_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kval_reg <= kval_next;
            merr_reg <= (f_ctl.item.op == OP_ERR);
            eom_reg  <= f_ctl.item.eom;
        end
    end

    assign out_valid    = out_vld_reg;
    assign kernel_value = kval_reg;
    assign mode_error   = merr_reg;
    assign eom_out      = eom_reg;

endmodule
`default_nettype wire

// File: sv/rbf_kernel_element_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbf_kernel_element_core: Gaussian / Laplacian RBF kernel, one element a cycle while results are popped
//
// Input queue side: present distance_sq and end_of_matrix with push; a request
// is taken on a clock edge where push is high and full is low.
// Result queue side: while empty is low, kernel_value, mode_error and
// end_of_matrix_out hold the oldest result; pop takes it.
// Configuration: cfg_valid with cfg_index / cfg_data writes kernel_mode (0),
// scale_coeff (1) or sigma_infinite (2); cfg_ready is always high. Write only
// while no request is in flight.
// From the accepting edge to empty falling, a request passes the queue slot,
// 24 square-root digit stages, the exponent product, 45 series stages of three
// per term, 31 exp(-1) stages and the result register. Throughput: one request
// per cycle while the consumer pops, set by the fully pipelined back end.
// When the consumer does not pop, the whole back end holds; the two-entry
// request queue then fills and raises full.
// Reset clears all valid flags and loads the register defaults.
// ----------------------------------------------------------------------------
module rbf_kernel_element_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [rbfk_pkg::DIST_W-1:0]        distance_sq,
    input  wire logic                               end_of_matrix,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic signed [rbfk_pkg::KVAL_W-1:0]      kernel_value,
    output logic                                    mode_error,
    output logic                                    end_of_matrix_out,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [rbfk_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rbfk_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import rbfk_pkg::*;

    item_t              front_item;
    logic [COEFF_W-1:0] scale_coeff;
    item_t              q_item;
    logic               q_empty;
    logic               adv;
    logic               sq_valid;
    item_t              sq_item;
    logic [ROOT_W-1:0]  sq_root;
    logic               res_valid;

    // Advance the back end whenever the result register is free or drained
    assign adv   = !res_valid || pop;
    assign empty = !res_valid;

    rbfk_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .distance_sq   (distance_sq),
        .end_of_matrix (end_of_matrix),
        .item          (front_item),
        .scale_coeff   (scale_coeff)
    );

    rbfk_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (push),
        .wr_item (front_item),
        .full    (full),
        .rd      (adv),
        .empty   (q_empty),
        .rd_item (q_item)
    );

    rbfk_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (!q_empty),
        .in_item   (q_item),
        .out_valid (sq_valid),
        .out_item  (sq_item),
        .out_root  (sq_root)
    );

    rbfk_exp u_exp (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (sq_valid),
        .in_item      (sq_item),
        .in_root      (sq_root),
        .scale_coeff  (scale_coeff),
        .out_valid    (res_valid),
        .kernel_value (kernel_value),
        .mode_error   (mode_error),
        .eom_out      (end_of_matrix_out)
    );

`ifndef ASSERT_OFF
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && mode_error) |-> (kernel_value == '0))
        else $error("mode error result carries a nonzero value");
`endif

endmodule
`default_nettype wire
